// ===== rtl/core/nwt_pkg.sv =====
// Shared types, constants and register codes of the NACK window tracker.
`default_nettype none
package nwt_pkg;

   // Window geometry.
   localparam int WINDOW = 64;
   localparam int IDX_W  = $clog2(WINDOW);
   localparam int LEN_W  = $clog2(WINDOW + 1);

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address is four times the index).
   typedef enum logic [2:0] {
      REG_MISSING_WAIT      = 3'd0,
      REG_NACKED_WAIT       = 3'd1,
      REG_MAX_RESEND        = 3'd2,
      REG_BURST_LIMIT       = 3'd3,
      REG_KEYFRAME_INTERVAL = 3'd4,
      REG_KEYFRAME_ENABLE   = 3'd5,
      REG_BACK_JUMP_LIMIT   = 3'd6,
      REG_UNUSED            = 3'd7
   } reg_idx_type;

   // State of one window entry.
   typedef enum logic [1:0] {
      ST_MISSING  = 2'd0,
      ST_RECEIVED = 2'd1,
      ST_NACKED   = 2'd2,
      ST_GIVEUP   = 2'd3
   } entry_st_type;

   // One entry as held in a cell; nack marks it for the emission pass.
   typedef struct packed {
      entry_st_type st;
      logic [31:0]  tstamp;
      logic [3:0]   count;
      logic         nack;
   } entry_type;

   // Everything the scan unit needs besides the entry itself.
   typedef struct packed {
      logic        active;
      logic [15:0] entry_seq;
      logic [15:0] seq;
      logic [31:0] now_ms;
      logic [15:0] missing_wait;
      logic [15:0] nacked_wait;
      logic [3:0]  max_resend;
   } scan_ctx_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECIDE,
      FSM_SCAN,
      FSM_CHECK,
      FSM_KEY,
      FSM_EMIT,
      FSM_APPEND
   } fsm_type;

endpackage
`default_nettype wire

// ===== rtl/core/nwt_if.sv =====
// Request and response channel interfaces of the NACK window tracker.
`default_nettype none

interface nwt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] seq;
   logic [31:0] now_ms;
   modport source (output valid, output seq, output now_ms, input ready);
   modport sink   (input valid, input seq, input now_ms, output ready);
endinterface

interface nwt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] nack_seq;
   logic        keyframe_request;
   logic        is_last;
   modport source (output valid, output nack_seq, output keyframe_request,
                   output is_last, input ready);
   modport sink   (input valid, input nack_seq, input keyframe_request,
                   input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nack_window_tracker_top.sv =====
// Top level of the NACK window tracker: sequencer, cell ring and register file.
//
//   channel   dir   signals                                         handshake
//   req       in    seq[15:0], now_ms[31:0]                         valid/ready
//   rsp       out   nack_seq[15:0], keyframe_request, is_last       valid/ready
//   csr       in    psel, penable, pwrite, paddr[4:0], pwdata       APB, pready=1
//
// One request at a time. It passes a decide step, one rotation of the cell ring
// through the scan unit (skipped on an empty window), a check step, a second
// rotation to emit flagged entries (only when NACKs are pending) and an append
// step for the new entries; a burst instead ends in a keyframe request or nothing.
// A stalled response holds the emission pass at the entry it waits on.
// Reset empties the window and loads the register defaults; no clearing pass.
`default_nettype none
module nack_window_tracker_top (
   input  wire                                clock,
   input  wire                                reset,
   nwt_req_if.sink                            req,
   nwt_rsp_if.source                          rsp,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire [nwt_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire [nwt_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [nwt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import nwt_pkg::*;

   // Configuration registers.
   logic [15:0] missing_wait_ff, nacked_wait_ff, kf_interval_ff, back_limit_ff;
   logic [3:0]  max_resend_ff;
   logic [7:0]  burst_limit_ff;
   logic        kf_enable_ff;
   reg_idx_type reg_idx;
   logic        csr_wr;

   assign reg_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         missing_wait_ff <= 16'd12;
         nacked_wait_ff  <= 16'd155;
         max_resend_ff   <= 4'd3;
         burst_limit_ff  <= 8'd100;
         kf_interval_ff  <= 16'd3000;
         kf_enable_ff    <= 1'b0;
         back_limit_ff   <= 16'd1000;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_MISSING_WAIT:      missing_wait_ff <= pwdata[15:0];
            REG_NACKED_WAIT:       nacked_wait_ff  <= pwdata[15:0];
            REG_MAX_RESEND:        max_resend_ff   <= pwdata[3:0];
            REG_BURST_LIMIT:       burst_limit_ff  <= pwdata[7:0];
            REG_KEYFRAME_INTERVAL: kf_interval_ff  <= pwdata[15:0];
            REG_KEYFRAME_ENABLE:   kf_enable_ff    <= pwdata[0];
            REG_BACK_JUMP_LIMIT:   back_limit_ff   <= pwdata[15:0];
            REG_UNUSED:            ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (reg_idx)
         REG_MISSING_WAIT:      prdata = {16'd0, missing_wait_ff};
         REG_NACKED_WAIT:       prdata = {16'd0, nacked_wait_ff};
         REG_MAX_RESEND:        prdata = {28'd0, max_resend_ff};
         REG_BURST_LIMIT:       prdata = {24'd0, burst_limit_ff};
         REG_KEYFRAME_INTERVAL: prdata = {16'd0, kf_interval_ff};
         REG_KEYFRAME_ENABLE:   prdata = {31'd0, kf_enable_ff};
         REG_BACK_JUMP_LIMIT:   prdata = {16'd0, back_limit_ff};
         REG_UNUSED:            prdata = '0;
      endcase
   end

   // Sequencer and window registers.
   fsm_type           fsm_ff, fsm_in;
   logic [15:0]       seq_ff, seq_in;
   logic [31:0]       now_ff, now_in;
   logic [15:0]       oldest_ff, oldest_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  old_len_ff, old_len_in;
   logic [31:0]       lkt_ff, lkt_in;
   logic [15:0]       cur_ff, cur_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic              app_ff, app_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [LEN_W-1:0]  n_ff, n_in;
   logic [LEN_W-1:0]  sent_ff, sent_in;

   // Response register.
   logic              rv_ff, rv_in;
   logic [15:0]       rseq_ff, rseq_in;
   logic              rkf_ff, rkf_in;
   logic              rlast_ff, rlast_in;

   // Ring control.
   entry_type         cq [WINDOW];
   entry_type         tail_data;
   entry_type         new_entry;
   entry_type         head_upd;
   scan_ctx_type      ctx;
   logic              shift_en;
   logic              wr_en;

   // Decide-cycle arithmetic.
   logic [15:0]       d_cur, d_fwd, d_back;
   logic              d_near, d_restart;
   logic              out_free;
   logic              pos_last;

   assign out_free = !rv_ff || rsp.ready;
   assign pos_last = (pos_ff == IDX_W'(WINDOW - 1));

   assign d_cur     = (len_ff != '0) ? (oldest_ff + 16'(len_ff) - 16'd1) : (seq_ff - 16'd1);
   assign d_fwd     = seq_ff - d_cur;
   assign d_back    = d_cur - seq_ff;
   assign d_near    = d_fwd < 16'(WINDOW);
   assign d_restart = !d_near && !(d_back < back_limit_ff);

   // Scan context for the head cell.
   assign ctx.active       = {1'b0, pos_ff} < old_len_ff;
   assign ctx.entry_seq    = oldest_ff + 16'(pos_ff);
   assign ctx.seq          = seq_ff;
   assign ctx.now_ms       = now_ff;
   assign ctx.missing_wait = missing_wait_ff;
   assign ctx.nacked_wait  = nacked_wait_ff;
   assign ctx.max_resend   = max_resend_ff;

   nwt_head u_head (
      .ent (cq[0]),
      .ctx (ctx),
      .upd (head_upd)
   );

   // Entry appended in the append phase; the last one is the request itself.
   assign new_entry.st     = (j_ff == k_ff) ? ST_RECEIVED : ST_MISSING;
   assign new_entry.tstamp = now_ff;
   assign new_entry.count  = 4'd0;
   assign new_entry.nack   = 1'b0;

   // Cell ring: each cell takes its right neighbor; the last takes the tail data.
   for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
      entry_type sdata;
      if (gi == WINDOW - 1) begin : g_tail
         assign sdata = tail_data;
      end else begin : g_mid
         assign sdata = cq[gi + 1];
      end
      nwt_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .shift_data (sdata),
         .wr_en      (wr_en && (len_ff == LEN_W'(gi))),
         .wr_data    (new_entry),
         .q          (cq[gi])
      );
   end

   assign req.ready            = (fsm_ff == FSM_IDLE);
   assign rsp.valid            = rv_ff;
   assign rsp.nack_seq         = rseq_ff;
   assign rsp.keyframe_request = rkf_ff;
   assign rsp.is_last          = rlast_ff;

   // Next state and datapath control.
   always_comb begin
      fsm_in     = fsm_ff;
      seq_in     = seq_ff;
      now_in     = now_ff;
      oldest_in  = oldest_ff;
      len_in     = len_ff;
      old_len_in = old_len_ff;
      lkt_in     = lkt_ff;
      cur_in     = cur_ff;
      k_in       = k_ff;
      app_in     = app_ff;
      pos_in     = pos_ff;
      j_in       = j_ff;
      n_in       = n_ff;
      sent_in    = sent_ff;
      rv_in      = rv_ff && !rsp.ready;
      rseq_in    = rseq_ff;
      rkf_in     = rkf_ff;
      rlast_in   = rlast_ff;
      shift_en   = 1'b0;
      wr_en      = 1'b0;
      tail_data  = cq[0];

      unique case (fsm_ff)
         FSM_IDLE: begin
            if (req.valid) begin
               seq_in = req.seq;
               now_in = req.now_ms;
               fsm_in = FSM_DECIDE;
            end
         end

         // Reference point, restart test and append length.
         FSM_DECIDE: begin
            pos_in = '0;
            n_in   = '0;
            j_in   = IDX_W'(1);
            if (d_restart) begin
               len_in     = '0;
               old_len_in = '0;
               cur_in     = seq_ff - 16'd1;
               k_in       = IDX_W'(1);
               app_in     = 1'b1;
               fsm_in     = FSM_CHECK;
            end else begin
               old_len_in = len_ff;
               cur_in     = d_cur;
               k_in       = d_fwd[IDX_W-1:0];
               app_in     = d_near;
               fsm_in     = (len_ff != '0) ? FSM_SCAN : FSM_CHECK;
            end
         end

         // Rotate the whole ring once through the scan unit.
         FSM_SCAN: begin
            shift_en  = 1'b1;
            tail_data = head_upd;
            n_in      = n_ff + LEN_W'(head_upd.nack);
            pos_in    = pos_ff + IDX_W'(1);
            if (pos_last) begin
               fsm_in = FSM_CHECK;
            end
         end

         // Burst test: keyframe path, NACK emission or append.
         FSM_CHECK: begin
            pos_in  = '0;
            sent_in = '0;
            if (16'(n_ff) > 16'(burst_limit_ff) && (now_ff - lkt_ff) >= {16'd0, kf_interval_ff}) begin
               len_in = '0;
               if (kf_enable_ff) begin
                  lkt_in = now_ff;
                  fsm_in = FSM_KEY;
               end else begin
                  fsm_in = FSM_IDLE;
               end
            end else if (n_ff != '0) begin
               fsm_in = FSM_EMIT;
            end else begin
               fsm_in = FSM_APPEND;
            end
         end

         FSM_KEY: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rseq_in  = 16'd0;
               rkf_in   = 1'b1;
               rlast_in = 1'b1;
               fsm_in   = FSM_IDLE;
            end
         end

         // Rotate again, sending each flagged entry oldest first.
         FSM_EMIT: begin
            if (!cq[0].nack || out_free) begin
               shift_en       = 1'b1;
               tail_data      = cq[0];
               tail_data.nack = 1'b0;
               pos_in         = pos_ff + IDX_W'(1);
               if (cq[0].nack) begin
                  rv_in    = 1'b1;
                  rseq_in  = ctx.entry_seq;
                  rkf_in   = 1'b0;
                  rlast_in = (sent_ff + LEN_W'(1)) == n_ff;
                  sent_in  = sent_ff + LEN_W'(1);
               end
               if (pos_last) begin
                  fsm_in = FSM_APPEND;
               end
            end
         end

         // One new entry per cycle; a full window drops its oldest entry.
         FSM_APPEND: begin
            if (!app_ff || k_ff == '0) begin
               fsm_in = FSM_IDLE;
            end else begin
               if (len_ff == LEN_W'(WINDOW)) begin
                  shift_en  = 1'b1;
                  tail_data = new_entry;
                  oldest_in = oldest_ff + 16'd1;
               end else begin
                  wr_en  = 1'b1;
                  len_in = len_ff + LEN_W'(1);
                  if (len_ff == '0) begin
                     oldest_in = cur_ff + 16'd1;
                  end
               end
               j_in = j_ff + IDX_W'(1);
               if (j_ff == k_ff) begin
                  fsm_in = FSM_IDLE;
               end
            end
         end

         default: fsm_in = FSM_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff    <= FSM_IDLE;
         oldest_ff <= '0;
         len_ff    <= '0;
         lkt_ff    <= '0;
         rv_ff     <= 1'b0;
      end else begin
         fsm_ff    <= fsm_in;
         oldest_ff <= oldest_in;
         len_ff    <= len_in;
         lkt_ff    <= lkt_in;
         rv_ff     <= rv_in;
      end
   end

   // Working registers of the current request and the response payload.
   always_ff @(posedge clock) begin
      seq_ff     <= seq_in;
      now_ff     <= now_in;
      old_len_ff <= old_len_in;
      cur_ff     <= cur_in;
      k_ff       <= k_in;
      app_ff     <= app_in;
      pos_ff     <= pos_in;
      j_ff       <= j_in;
      n_ff       <= n_in;
      sent_ff    <= sent_in;
      rseq_ff    <= rseq_in;
      rkf_ff     <= rkf_in;
      rlast_ff   <= rlast_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/nwt_cell.sv =====
// One window cell: holds an entry, takes its neighbor's entry or a direct write.
`default_nettype none
module nwt_cell (
   input  wire                   clock,
   input  wire                   shift_en,
   input  nwt_pkg::entry_type    shift_data,
   input  wire                   wr_en,
   input  nwt_pkg::entry_type    wr_data,
   output nwt_pkg::entry_type    q
);
   import nwt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Shifting has priority; the sequencer never asks for both.
   always_comb begin
      priority if (shift_en) begin
         entry_in = shift_data;
      end else if (wr_en) begin
         entry_in = wr_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;
endmodule
`default_nettype wire

// ===== rtl/core/nwt_head.sv =====
// Scan unit at the head of the cell ring: ages one entry and decides its NACK.
`default_nettype none
module nwt_head (
   input  nwt_pkg::entry_type    ent,
   input  nwt_pkg::scan_ctx_type ctx,
   output nwt_pkg::entry_type    upd
);
   import nwt_pkg::*;

   logic [31:0] age;
   logic [4:0]  next_count;

   assign age        = ctx.now_ms - ent.tstamp;
   assign next_count = {1'b0, ent.count} + 5'd1;

   // Matching number is received; otherwise missing or nacked entries may age out.
   always_comb begin
      upd      = ent;
      upd.nack = 1'b0;
      if (ctx.active) begin
         if (ctx.entry_seq == ctx.seq) begin
            upd.st = ST_RECEIVED;
         end else if (ent.st == ST_MISSING && age > {16'd0, ctx.missing_wait}) begin
            upd.st     = ST_NACKED;
            upd.tstamp = ctx.now_ms;
            upd.count  = (ent.count < 4'd15) ? next_count[3:0] : 4'd15;
            upd.nack   = 1'b1;
         end else if (ent.st == ST_NACKED && age > {16'd0, ctx.nacked_wait} &&
                      ent.count <= ctx.max_resend) begin
            upd.tstamp = ctx.now_ms;
            upd.nack   = 1'b1;
            if (next_count > {1'b0, ctx.max_resend}) begin
               upd.st = ST_GIVEUP;
            end
            upd.count = (next_count > 5'd15) ? 4'd15 : next_count[3:0];
         end
      end
   end
endmodule
`default_nettype wire

// ===== tb/sv/nack_window_tracker_top_tb.sv =====
// Self-checking testbench of the NACK window tracker against the response channel.
module nack_window_tracker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nwt_pkg::*;

   typedef struct packed {
      logic [15:0] seq;
      logic [31:0] now_ms;
   } pkt_type;

   typedef struct packed {
      logic [15:0] nack_seq;
      logic        keyframe_request;
      logic        is_last;
   } nack_type;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   nwt_req_if req ();
   nwt_rsp_if rsp ();

   nack_window_tracker_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Predictor state: entries by slot, window bounds and registers.
   entry_st_type win_st [WINDOW];
   logic [31:0]  win_time [WINDOW];
   logic [3:0]   win_count [WINDOW];
   logic [15:0]  oldest;
   int unsigned  win_len;
   int unsigned  head;
   logic [31:0]  last_key;
   logic [31:0]  cfg_missing_wait, cfg_nacked_wait, cfg_max_resend, cfg_burst_limit;
   logic [31:0]  cfg_key_interval, cfg_key_enable, cfg_back_limit;

   pkt_type  pkt_queue[$];
   nack_type nack_queue[$];
   int       errors = 0;
   int       send_idle = 34, recv_idle = 47;
   int       hold_cycles = 0;
   int       quiet = 0;
   logic     done = 1'b0;
   logic [31:0] clock_ms = 0;
   logic     accepted = 1'b0;

   // Compute the responses caused by one accepted request.
   task automatic predict_nacks(input pkt_type p);
      logic [15:0] cur, fwd, back, s;
      logic [31:0] age, c;
      logic [15:0] hits[$];
      logic have;
      int unsigned old_len, e, total, drop;
      nack_type r;
      have = win_len > 0;
      cur = have ? 16'(oldest + win_len - 1) : 16'(p.seq - 1);
      fwd = p.seq - cur;
      back = cur - p.seq;
      if (!(fwd < WINDOW) && !(32'(back) < cfg_back_limit)) begin
         win_len = 0; head = 0; have = 1'b0;
         cur = 16'(p.seq - 1); fwd = 16'd1;
      end
      old_len = win_len;
      if (have) begin
         for (int i = 0; i < old_len; i++) begin
            e = (head + i) % WINDOW;
            s = 16'(oldest + i);
            age = p.now_ms - win_time[e];
            if (s == p.seq) begin
               win_st[e] = ST_RECEIVED;
            end else if (win_st[e] == ST_MISSING && age > cfg_missing_wait) begin
               hits = {hits, s};
               win_st[e] = ST_NACKED;
               win_time[e] = p.now_ms;
               win_count[e] = (win_count[e] < 4'd15) ? 4'(win_count[e] + 1) : 4'd15;
            end else if (win_st[e] == ST_NACKED && age > cfg_nacked_wait &&
                         32'(win_count[e]) <= cfg_max_resend) begin
               c = 32'(win_count[e]) + 32'd1;
               hits = {hits, s};
               win_time[e] = p.now_ms;
               if (c > cfg_max_resend) win_st[e] = ST_GIVEUP;
               win_count[e] = (c > 32'd15) ? 4'd15 : c[3:0];
            end
         end
      end
      if (fwd < WINDOW) begin
         total = old_len + fwd;
         if (total > WINDOW) begin
            drop = total - WINDOW;
            head = (head + drop) % WINDOW;
            oldest = 16'(oldest + drop);
            win_len = win_len - drop;
         end
         if (win_len == 0) begin
            head = 0;
            oldest = 16'(cur + 1);
         end
         for (int j = 1; j <= fwd; j++) begin
            s = 16'(cur + j);
            e = (head + win_len) % WINDOW;
            win_st[e] = (s == p.seq) ? ST_RECEIVED : ST_MISSING;
            win_time[e] = p.now_ms;
            win_count[e] = 4'd0;
            win_len++;
         end
      end
      if (hits.size() > cfg_burst_limit && (p.now_ms - last_key) >= cfg_key_interval) begin
         win_len = 0; head = 0;
         if (cfg_key_enable[0]) begin
            last_key = p.now_ms;
            r.nack_seq = 16'd0; r.keyframe_request = 1'b1; r.is_last = 1'b1;
            nack_queue = {nack_queue, r};
         end
      end else begin
         foreach (hits[i]) begin
            r.nack_seq = hits[i]; r.keyframe_request = 1'b0;
            r.is_last = (i == hits.size() - 1);
            nack_queue = {nack_queue, r};
         end
      end
   endtask

   // Register write over the APB-style port, predictor updated alongside.
   task automatic write_reg(input reg_idx_type idx, input logic [31:0] value);
      @(negedge clock);
      psel = 1; penable = 0; pwrite = 1; paddr = CSR_ADDR_W'(4 * idx); pwdata = value;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      case (idx)
         REG_MISSING_WAIT:      cfg_missing_wait = value & 32'hFFFF;
         REG_NACKED_WAIT:       cfg_nacked_wait = value & 32'hFFFF;
         REG_MAX_RESEND:        cfg_max_resend = value & 32'hF;
         REG_BURST_LIMIT:       cfg_burst_limit = value & 32'hFF;
         REG_KEYFRAME_INTERVAL: cfg_key_interval = value & 32'hFFFF;
         REG_KEYFRAME_ENABLE:   cfg_key_enable = value & 32'h1;
         REG_BACK_JUMP_LIMIT:   cfg_back_limit = value & 32'hFFFF;
         default: ;
      endcase
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   // Wait until every queued request went in and every response came out.
   task automatic drain;
      while (pkt_queue.size() != 0 || req.valid || nack_queue.size() != 0) @(posedge clock);
      repeat (3 * WINDOW + 10) @(posedge clock);
   endtask

   task automatic push_pkt(input logic [15:0] seq, input logic [31:0] now_ms);
      pkt_type p;
      p.seq = seq; p.now_ms = now_ms;
      pkt_queue = {pkt_queue, p};
   endtask

   // Mostly an orderly stream with losses, reorders and jumps.
   task automatic random_stream(input int count);
      logic [15:0] sq;
      int pick;
      sq = 16'($urandom);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         clock_ms += $urandom_range(0, 40);
         if (pick < 60) sq = 16'(sq + $urandom_range(1, 4));
         else if (pick < 75) sq = 16'(sq - $urandom_range(0, 10));
         else if (pick < 85) sq = 16'(sq + $urandom_range(5, 70));
         else if (pick < 92) sq = 16'($urandom);
         else if (pick < 96) clock_ms = $urandom;
         else clock_ms += $urandom_range(100, 400);
         push_pkt(sq, clock_ms);
      end
   endtask

   // Driver: offer the oldest pending request at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || accepted) begin
         if (pkt_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            req.valid <= 1'b1;
            req.seq <= pkt_queue[0].seq;
            req.now_ms <= pkt_queue[0].now_ms;
            pkt_queue.delete(0);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) accepted <= req.valid && req.ready && !reset;

   // Receiver readiness, with an optional long hold-off.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !reset && ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // Monitor: predict on request, compare on response.
   always @(posedge clock) begin
      pkt_type p;
      nack_type want, got;
      if (!reset) begin
         if (req.valid && req.ready) begin
            p.seq = req.seq; p.now_ms = req.now_ms;
            predict_nacks(p);
         end
         if (rsp.valid && rsp.ready) begin
            got.nack_seq = rsp.nack_seq;
            got.keyframe_request = rsp.keyframe_request;
            got.is_last = rsp.is_last;
            if (nack_queue.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = nack_queue[0];
               nack_queue.delete(0);
               if (got.keyframe_request !== want.keyframe_request ||
                   got.is_last !== want.is_last ||
                   (!want.keyframe_request && got.nack_seq !== want.nack_seq) ||
                   (want.keyframe_request && got.nack_seq !== 16'd0)) begin
                  $display("%0t: response mismatch, expected seq %h key %b last %b,",
                           $time, want.nack_seq, want.keyframe_request, want.is_last,
                           " actual seq %h key %b last %b",
                           got.nack_seq, got.keyframe_request, got.is_last);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      if (reset || done || (req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0; req.seq = '0; req.now_ms = '0;
      rsp.ready = 1'b0;
      cfg_missing_wait = 12; cfg_nacked_wait = 155; cfg_max_resend = 3;
      cfg_burst_limit = 100; cfg_key_interval = 3000; cfg_key_enable = 0;
      cfg_back_limit = 1000;
      oldest = 0; win_len = 0; head = 0; last_key = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: small waits, every register written.
      write_reg(REG_MISSING_WAIT, 0);
      write_reg(REG_NACKED_WAIT, 0);
      write_reg(REG_MAX_RESEND, 2);
      write_reg(REG_BURST_LIMIT, 255);
      write_reg(REG_KEYFRAME_INTERVAL, 0);
      write_reg(REG_KEYFRAME_ENABLE, 1);
      write_reg(REG_BACK_JUMP_LIMIT, 65535);
      push_pkt(16'hFFFE, 0);
      push_pkt(16'h0003, 5);          // gap across the wrap
      push_pkt(16'h0003, 7);          // duplicate newest
      push_pkt(16'h0000, 9);          // older number fills a hole
      push_pkt(16'h0004, 20);
      push_pkt(16'h0005, 40);
      push_pkt(16'h0006, 60);         // repeats until given up
      push_pkt(16'h0007, 32'hFFFF_FFFF);
      push_pkt(16'h0040, 3);          // time went backwards, long gap
      push_pkt(16'h8000, 10);
      drain();
      write_reg(REG_BACK_JUMP_LIMIT, 0);  // no number behind is accepted
      write_reg(REG_MAX_RESEND, 15);
      write_reg(REG_BURST_LIMIT, 0);
      push_pkt(16'h1000, 100);
      push_pkt(16'h0FFF, 200);
      push_pkt(16'h1010, 300);
      push_pkt(16'h1020, 400);        // burst goes to a keyframe request
      push_pkt(16'h1021, 500);
      drain();
      write_reg(REG_KEYFRAME_ENABLE, 0);
      write_reg(REG_KEYFRAME_INTERVAL, 65535);
      write_reg(REG_BURST_LIMIT, 4);
      push_pkt(16'h2000, 600);
      push_pkt(16'h2030, 700);
      push_pkt(16'h203F, 800);
      push_pkt(16'h2080, 70000);
      drain();

      // Random phase one, with a long receiver hold-off.
      write_reg(REG_MISSING_WAIT, 12);
      write_reg(REG_NACKED_WAIT, 30);
      write_reg(REG_MAX_RESEND, 3);
      write_reg(REG_BURST_LIMIT, 20);
      write_reg(REG_KEYFRAME_INTERVAL, 3000);
      write_reg(REG_KEYFRAME_ENABLE, 1);
      write_reg(REG_BACK_JUMP_LIMIT, 1000);
      hold_cycles = 1500;
      random_stream(50);
      drain();

      // Random phase two, idling swapped, extreme waits.
      send_idle = 47; recv_idle = 34;
      write_reg(REG_MISSING_WAIT, 65535);
      write_reg(REG_NACKED_WAIT, 65535);
      write_reg(REG_MAX_RESEND, 0);
      write_reg(REG_BACK_JUMP_LIMIT, 1);
      random_stream(50);
      drain();

      // Random phase three, no idling.
      send_idle = 0; recv_idle = 0;
      write_reg(REG_MISSING_WAIT, 5);
      write_reg(REG_NACKED_WAIT, 10);
      write_reg(REG_MAX_RESEND, 15);
      write_reg(REG_BURST_LIMIT, 255);
      write_reg(REG_BACK_JUMP_LIMIT, 65535);
      random_stream(50);
      drain();

      done = 1'b1;
      if (errors == 0 && nack_queue.size() == 0 && pkt_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
